// File: rtl/srsd_pkg.sv
// Package for the sensor resistance settle detector.
// Holds field widths, register reset values, register indexes and the saturation helper.
// No dependencies.
package srsd_pkg;

  // Default ADC resolution.
  localparam int ADC_BITS_DEF = 12;

  // Field and state widths.
  localparam int LOAD_W    = 24;
  localparam int SUPPLY_W  = 16;
  localparam int TOL_W     = 10;
  localparam int REQ_W     = 8;
  localparam int RS_W      = 32;
  localparam int SUM_W     = 40;
  localparam int ELAPSED_W = 16;
  localparam int NUM_W     = LOAD_W + SUPPLY_W;
  localparam int SCALE_W   = 10;
  localparam int TP_W      = RS_W + TOL_W;

  // The tolerance is given in thousandths.
  localparam int TOL_SCALE = 1000;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Register reset values.
  localparam logic [LOAD_W-1:0]   LOAD_RST     = LOAD_W'(980000);
  localparam logic [SUPPLY_W-1:0] SUPPLY_RST   = SUPPLY_W'(64726);
  localparam logic [TOL_W-1:0]    TOL_RST      = TOL_W'(25);
  localparam logic [REQ_W-1:0]    REQUIRED_RST = REQ_W'(15);

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOAD_OHMS    = 2'd0,
    REG_SUPPLY_X16   = 2'd1,
    REG_TOLERANCE    = 2'd2,
    REG_REQUIRED     = 2'd3
  } cfg_reg_t;

  // Clamp a wide quotient to the 32-bit result range.
  function automatic logic [RS_W-1:0] sat_rs(input logic [SUM_W-1:0] v);
    logic [RS_W-1:0] r;
    r = (|v[SUM_W-1:RS_W]) ? '1 : v[RS_W-1:0];
    return r;
  endfunction

endpackage

// File: rtl/sensor_resistance_settle_detector_unit.sv
// Top level of the sensor resistance settle detector: sequencer, run state and output register.
// Depends on srsd_pkg, srsd_mul and srsd_div.
//
//   Channel  Ports                               Direction  Moves
//   in       in_valid, in_stall, in_sample       sink       one ADC sample per beat
//   out      out_valid, out_stall, out_*         source     one result per beat
//   cfg      cfg_we, cfg_index, cfg_wdata        sink       one register write per cycle
//
// An item needs no product when the sample is out of range, or is zero with no reference held;
// the longest items take the resistance division, the stability products and the run
// average. Their length is set by the 16-bit shift-add multiplier and the 20 steps of the
// radix-4 divider.
// Reset is synchronous and active low; it loads the register defaults and clears the run.
// A new sample is taken while the previous result still waits on out_stall; the finished
// result waits in the sequencer until the output register is free.
module sensor_resistance_settle_detector_unit
  import srsd_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADC_BITS-1:0]   in_sample,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RS_W-1:0]       out_rs_ohms,
  output logic                  out_reading_valid,
  output logic [REQ_W-1:0]      out_stable_count,
  output logic                  out_done_res,
  output logic [RS_W-1:0]       out_average_rs,
  output logic [ELAPSED_W-1:0]  out_elapsed_samples,
  // Configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SC_W  = ADC_BITS + 4;
  localparam int CMP_W = (SC_W > SUPPLY_W) ? SC_W : SUPPLY_W;
  localparam int MA_B_W = SUPPLY_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLASS,
    ST_MUL1,
    ST_DIV1,
    ST_EVAL,
    ST_MUL2,
    ST_TEST,
    ST_CHECK,
    ST_DIV2,
    ST_FINISH
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [LOAD_W-1:0]    load_r;
  logic [SUPPLY_W-1:0]  supply_r;
  logic [TOL_W-1:0]     tol_r;
  logic [REQ_W-1:0]     req_r;

  // Item and run state
  logic [ADC_BITS-1:0]  sample_r;
  logic [RS_W-1:0]      rs_r;
  logic                 valid_r;
  logic [RS_W-1:0]      ref_r;
  logic                 ref_valid_r;
  logic [REQ_W-1:0]     run_r;
  logic [SUM_W-1:0]     sum_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic                 done_flag_r;
  logic [RS_W-1:0]      avg_r;

  // Output register
  logic                 out_valid_r;
  logic [RS_W-1:0]      out_rs_r;
  logic                 out_reading_valid_r;
  logic [REQ_W-1:0]     out_count_r;
  logic                 out_done_r;
  logic [RS_W-1:0]      out_avg_r;
  logic [ELAPSED_W-1:0] out_elapsed_r;

  // Datapath signals
  logic [CMP_W-1:0]     scaled_c;
  logic [SUPPLY_W-1:0]  divs;
  logic                 zero_smp;
  logic                 nonpos;
  logic [RS_W-1:0]      diff;
  logic [REQ_W-1:0]     need;
  logic                 unstable;

  logic                 mula_start;
  logic [RS_W-1:0]      mula_a;
  logic [MA_B_W-1:0]    mula_b;
  logic                 mula_done;
  logic [RS_W+MA_B_W-1:0] mula_prod;

  logic                 mulb_start;
  logic                 mulb_done;
  logic [TP_W-1:0]      mulb_prod;

  logic                 div_start;
  logic [SUM_W-1:0]     div_dvd;
  logic [SUPPLY_W-1:0]  div_dvs;
  logic                 div_done;
  logic [SUM_W-1:0]     div_q;

  // Sample classification and operand selection.
  always_comb begin
    scaled_c = CMP_W'({sample_r, 4'b0000});
    divs     = SUPPLY_W'(scaled_c);
    zero_smp = (sample_r == '0);
    nonpos   = (scaled_c >= CMP_W'(supply_r));
    diff     = (rs_r >= ref_r) ? (rs_r - ref_r) : (ref_r - rs_r);
    need     = (req_r == '0) ? REQ_W'(1) : req_r;
    unstable = (mulb_prod > mula_prod[TP_W-1:0]);

    mula_start = ((state_r == ST_CLASS) && !zero_smp && !nonpos) ||
                 ((state_r == ST_EVAL) && valid_r && ref_valid_r);
    mula_a     = (state_r == ST_CLASS) ? RS_W'(load_r) : ref_r;
    mula_b     = (state_r == ST_CLASS) ? (supply_r - divs) : MA_B_W'(tol_r);
    mulb_start = (state_r == ST_EVAL) && valid_r && ref_valid_r;

    div_start = ((state_r == ST_MUL1) && mula_done) ||
                ((state_r == ST_CHECK) && (run_r >= need));
    div_dvd   = (state_r == ST_MUL1) ? mula_prod[NUM_W-1:0] : sum_r;
    div_dvs   = (state_r == ST_MUL1) ? divs : SUPPLY_W'(need);
  end

  // Shared multiplier: numerator, then tolerance times reference.
  srsd_mul #(
    .A_W (RS_W),
    .B_W (MA_B_W)
  ) u_mul_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mula_start),
    .a     (mula_a),
    .b     (mula_b),
    .done  (mula_done),
    .prod  (mula_prod)
  );

  // Difference times one thousand, run alongside the tolerance product.
  srsd_mul #(
    .A_W (RS_W),
    .B_W (SCALE_W)
  ) u_mul_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mulb_start),
    .a     (diff),
    .b     (SCALE_W'(TOL_SCALE)),
    .done  (mulb_done),
    .prod  (mulb_prod)
  );

  // Shared divider: resistance quotient, then run average.
  srsd_div #(
    .DVD_W (SUM_W),
    .DVS_W (SUPPLY_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer, run state, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      load_r      <= LOAD_RST;
      supply_r    <= SUPPLY_RST;
      tol_r       <= TOL_RST;
      req_r       <= REQUIRED_RST;
      ref_r       <= '0;
      ref_valid_r <= 1'b0;
      run_r       <= '0;
      sum_r       <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Register writes from the configuration port.
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_LOAD_OHMS:  load_r   <= cfg_wdata[LOAD_W-1:0];
          REG_SUPPLY_X16: supply_r <= cfg_wdata[SUPPLY_W-1:0];
          REG_TOLERANCE:  tol_r    <= cfg_wdata[TOL_W-1:0];
          REG_REQUIRED:   req_r    <= cfg_wdata[REQ_W-1:0];
          default: ;
        endcase
      end

      // The output beat leaves when the sink takes it; a finishing item refills it instead.
      if (out_valid_r && !out_stall && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            sample_r    <= in_sample;
            done_flag_r <= 1'b0;
            avg_r       <= '0;
            if (elapsed_r != '1) begin
              elapsed_r <= elapsed_r + 1'b1;
            end
            state_r <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          if (zero_smp) begin
            rs_r    <= '1;
            valid_r <= 1'b1;
            state_r <= ST_EVAL;
          end else if (nonpos) begin
            rs_r    <= '0;
            valid_r <= 1'b0;
            state_r <= ST_EVAL;
          end else begin
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          if (mula_done) begin
            state_r <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            rs_r    <= sat_rs(div_q);
            valid_r <= (div_q != '0);
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (!valid_r) begin
            ref_r       <= '0;
            ref_valid_r <= 1'b0;
            run_r       <= '0;
            sum_r       <= '0;
            state_r     <= ST_FINISH;
          end else if (!ref_valid_r) begin
            ref_r       <= rs_r;
            ref_valid_r <= 1'b1;
            run_r       <= '0;
            sum_r       <= '0;
            state_r     <= ST_FINISH;
          end else begin
            state_r <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          // The tolerance product has the longer multiplier, so it finishes last.
          if (mula_done) begin
            state_r <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (unstable) begin
            ref_r   <= rs_r;
            run_r   <= '0;
            sum_r   <= '0;
            state_r <= ST_FINISH;
          end else begin
            sum_r   <= sum_r + SUM_W'(rs_r);
            run_r   <= run_r + 1'b1;
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state_r <= (run_r >= need) ? ST_DIV2 : ST_FINISH;
        end
        ST_DIV2: begin
          if (div_done) begin
            avg_r       <= sat_rs(div_q);
            done_flag_r <= 1'b1;
            state_r     <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r         <= 1'b1;
            out_rs_r            <= rs_r;
            out_reading_valid_r <= valid_r;
            out_count_r         <= run_r;
            out_done_r          <= done_flag_r;
            out_avg_r           <= avg_r;
            out_elapsed_r       <= elapsed_r;
            // A completed run starts the calibration over.
            if (done_flag_r) begin
              ref_r       <= '0;
              ref_valid_r <= 1'b0;
              run_r       <= '0;
              sum_r       <= '0;
              elapsed_r   <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_rs_ohms         = out_rs_r;
  assign out_reading_valid   = out_reading_valid_r;
  assign out_stable_count    = out_count_r;
  assign out_done_res        = out_done_r;
  assign out_average_rs      = out_avg_r;
  assign out_elapsed_samples = out_elapsed_r;

`ifndef SYNTHESIS
  // A finished run always comes from a valid reading with a nonzero count.
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_reading_valid_r && (out_count_r != '0)))
    else $error("done reported without a valid stable run");

  // An invalid reading clears the run and never finishes it.
  a_invalid_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_reading_valid_r) |-> ((out_count_r == '0) && !out_done_r))
    else $error("invalid reading left a stable count or done");

  // Without a reference there is no run in progress.
  a_no_ref_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    !ref_valid_r |-> ((run_r == '0) && (sum_r == '0)))
    else $error("run state present without a reference");

  // The difference product is always ready before the tolerance product.
  a_diff_first: assert property (@(posedge clk) disable iff (!rst_n)
    mulb_done |-> ((state_r == ST_MUL2) && !mula_done))
    else $error("difference product finished out of order");
`endif

endmodule

// File: rtl/srsd_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on nothing; instantiated by the settle detector top level.
module srsd_mul #(
  parameter int A_W = 32,
  parameter int B_W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] prod
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic [P_W-1:0]   prod_r;
  logic [P_W-1:0]   prod_nxt;
  logic [A_W-1:0]   a_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [A_W:0]     hi_sum;

  // Add the multiplicand into the upper half when the low bit is set, then shift right.
  always_comb begin
    hi_sum = prod_r[0] ? ({1'b0, prod_r[P_W-1:B_W]} + {1'b0, a_r})
                       : {1'b0, prod_r[P_W-1:B_W]};
    prod_nxt = {hi_sum, prod_r[B_W-1:1]};
  end

  // Step counter and product register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        prod_r <= {{A_W{1'b0}}, b};
        a_r    <= a;
        cnt_r  <= CNT_W'(B_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        prod_r <= prod_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;

`ifndef SYNTHESIS
  // A new operation never starts on top of one in progress.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("multiplier started while busy");
`endif

endmodule

// File: rtl/srsd_div.sv
// Restoring divider that retires two quotient bits per cycle.
// Depends on nothing; shared by both divisions of the settle detector.
module srsd_div #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  // The dividend is padded to an even width so that each cycle takes two bits.
  localparam int QW    = DVD_W + (DVD_W % 2);
  localparam int STEPS = QW / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [QW-1:0]    q_r;
  logic [QW-1:0]    q_nxt;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  // Two dependent shift-compare-subtract steps on a narrow remainder.
  always_comb begin
    logic [DVS_W:0] t;
    logic           qbit;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    for (int k = 0; k < 2; k++) begin
      t = {rem_nxt, q_nxt[QW-1]};
      if (t >= {1'b0, dvs_r}) begin
        t    = t - {1'b0, dvs_r};
        qbit = 1'b1;
      end else begin
        qbit = 1'b0;
      end
      rem_nxt = t[DVS_W-1:0];
      q_nxt   = {q_nxt[QW-2:0], qbit};
    end
  end

  // Step counter, remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= QW'(dividend);
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= CNT_W'(STEPS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r    <= q_nxt;
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r[DVD_W-1:0];

`ifndef SYNTHESIS
  // The shared divider is only handed a new operand pair when it is free.
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
`endif

endmodule
